### src/bmp_pixel_unpacker_top_macros.svh
// ---------------------------------------------------------------------------
// BMP pixel unpacker assertion macros
// Shared concurrent assertion shorthands, clocked on clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef BMP_PIXEL_UNPACKER_TOP_MACROS_SVH
`define BMP_PIXEL_UNPACKER_TOP_MACROS_SVH

// Same-cycle implication.
`define BPU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Plain invariant.
`define BPU_ASSERT_ALW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

### src/bpu_pkg.sv
// ---------------------------------------------------------------------------
// BMP pixel unpacker package
// Format codes, register indexes, sizes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpu_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int PAL_ENTRIES  = 256;
  localparam int PAL_AW       = $clog2(PAL_ENTRIES);
  localparam int COL_W        = 13;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = FIFO_AW + 1;

  // pixel_format codes
  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_24BPP = 3'd3;
  localparam logic [2:0] FMT_32BPP = 3'd4;

  // configuration register indexes
  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_IMAGE_WIDTH  = 1'b1;

  // request kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
    logic        row_end;
  } pixel_t;

endpackage

### src/bmp_pixel_unpacker_top.sv
// ---------------------------------------------------------------------------
// BMP pixel unpacker
// Decodes BMP pixel-array bytes into RGB pixels through a palette memory.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per handshake:
//   kind 0 loads palette entry palette_index with palette_color, kind 1
//   delivers the next pixel-array byte in data_byte. Output channel
//   (out_valid/out_ready) returns one pixel per handshake with red, green,
//   blue, last_of_run (last pixel of its byte) and row_end (last of its row).
//   The configuration channel writes pixel_format (index 0) and image_width
//   (index 1); write it only while the block is idle.
//   Path: a byte passes the holding stage, the lookup stage and the output
//   queue before its first pixel appears; its further pixels follow in order.
//   Throughput: one request per cycle for padding bytes, palette loads and,
//   while the queue has room, 8/24/32bpp bytes; a 4bpp byte of two pixels
//   or a 1bpp byte of up to eight holds the input, one pixel issued per cycle.
//   Reset clears the stream state, sets 24bpp and width 1; the palette is
//   undefined until loaded. When the receiver stalls, pixels collect in a
//   four-entry output queue; once it runs out of room the decoder holds and
//   the input stalls. Nothing is dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bmp_pixel_unpacker_top_macros.svh"

module bmp_pixel_unpacker_top (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  // pixel channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last_of_run,
  output logic        row_end
);
  import bpu_pkg::*;

  // configuration
  logic [2:0]       pixel_format;
  logic [COL_W-1:0] image_width;

  // holding stage: the request being decoded
  logic             h_valid;
  logic             h_kind;
  logic [7:0]       h_byte;
  logic [7:0]       h_pidx;
  logic [23:0]      h_pcolor;

  // stream state
  logic [COL_W-1:0] col, col_next;
  logic [1:0]       pad, pad_next;
  logic [1:0]       phase, phase_next;
  logic [23:0]      asm_rgb, asm_next;
  logic [2:0]       sub, sub_next;

  // palette memory
  logic [23:0]      pal_mem [PAL_ENTRIES];
  logic [23:0]      mem_q;
  logic             mem_we;
  logic             mem_re;
  logic [PAL_AW-1:0] rd_addr;

  // lookup stage
  logic             p_valid;
  logic             p_pal;
  logic [23:0]      p_rgb;
  logic             p_last;
  logic             p_end;

  // output queue
  pixel_t           q_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] q_wr, q_rd;
  logic [FIFO_CW-1:0] q_count;
  logic             q_push, q_pop;
  pixel_t           q_head;

  // decode signals
  logic [COL_W-1:0] w_eff;
  logic             end_now;
  logic [1:0]       rb_low;
  logic [1:0]       pad_arm;
  logic             h_done;
  logic             emit_req;
  logic             emit_pal;
  logic             emit_clr;
  logic [7:0]       emit_idx;
  logic [23:0]      emit_rgb;
  logic             emit_last;
  logic             credit;
  logic             issue;

  // -------------------------------------------------------------------------
  // Configuration: always ready; index 0 writes pixel_format, index 1 image_width.
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_24BPP;
      image_width  <= COL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PIXEL_FORMAT) begin
        pixel_format <= cfg_data[2:0];
      end else begin
        image_width <= cfg_data;
      end
    end
  end

  // Clamp the width into 1 .. MAX_WIDTH.
  always_comb begin
    if (image_width == '0) begin
      w_eff = COL_W'(1);
    end else if (image_width > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
  end

  // Row length in bytes, modulo four, and the padding it leaves.
  always_comb begin
    logic [COL_W:0] w7, w1;
    w7 = {1'b0, w_eff} + (COL_W+1)'(7);
    w1 = {1'b0, w_eff} + (COL_W+1)'(1);
    case (pixel_format)
      FMT_1BPP:  rb_low = w7[4:3];
      FMT_4BPP:  rb_low = w1[2:1];
      FMT_8BPP:  rb_low = w_eff[1:0];
      FMT_24BPP: rb_low = 2'(w_eff[1:0] + {w_eff[0], 1'b0});
      default:   rb_low = 2'd0;
    endcase
    pad_arm = 2'(2'd0 - rb_low);
  end

  assign end_now = ({1'b0, col} + (COL_W+1)'(1)) >= {1'b0, w_eff};

  // -------------------------------------------------------------------------
  // Holding stage: take a new request once the current one finishes.
  // -------------------------------------------------------------------------
  assign in_ready = !h_valid || h_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      h_valid <= 1'b1;
    end else if (h_done) begin
      h_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_kind   <= kind;
      h_byte   <= data_byte;
      h_pidx   <= palette_index;
      h_pcolor <= palette_color;
    end
  end

  // Issue only with room guaranteed for everything already in flight.
  assign credit = (q_count + FIFO_CW'(p_valid)) < FIFO_CW'(FIFO_DEPTH);

  // -------------------------------------------------------------------------
  // Decoder: one pixel per cycle at most; column and sub-pixel index advance only on issue.
  // -------------------------------------------------------------------------
  always_comb begin
    col_next   = col;
    pad_next   = pad;
    phase_next = phase;
    asm_next   = asm_rgb;
    sub_next   = sub;
    h_done     = 1'b0;
    mem_we     = 1'b0;
    emit_req   = 1'b0;
    emit_pal   = 1'b0;
    emit_clr   = 1'b0;
    emit_idx   = 8'd0;
    emit_rgb   = 24'd0;
    emit_last  = 1'b0;
    issue      = 1'b0;

    if (h_valid) begin
      if (h_kind == KIND_PALETTE) begin
        // palette load: write the entry and retire
        mem_we = 1'b1;
        h_done = 1'b1;
      end else if (pixel_format > FMT_32BPP) begin
        h_done = 1'b1;
      end else if (pad != 2'd0) begin
        // drop a row padding byte
        pad_next = pad - 2'd1;
        h_done   = 1'b1;
      end else begin
        case (pixel_format)
          FMT_1BPP: begin
            emit_req  = 1'b1;
            emit_rgb  = h_byte[~sub] ? 24'hFF_FFFF : 24'd0;
            emit_last = end_now || (sub == 3'd7);
          end
          FMT_4BPP: begin
            emit_req  = 1'b1;
            emit_pal  = 1'b1;
            emit_idx  = sub[0] ? {4'd0, h_byte[3:0]} : {4'd0, h_byte[7:4]};
            emit_last = sub[0] || end_now;
          end
          FMT_8BPP: begin
            emit_req  = 1'b1;
            emit_pal  = 1'b1;
            emit_idx  = h_byte;
            emit_last = 1'b1;
          end
          FMT_24BPP: begin
            if (phase >= 2'd2) begin
              emit_req  = 1'b1;
              emit_clr  = 1'b1;
              emit_rgb  = {h_byte, asm_rgb[15:0]};
              emit_last = 1'b1;
            end else begin
              if (phase == 2'd0) begin
                asm_next = {16'd0, h_byte};
              end else begin
                asm_next = {asm_rgb[23:16], h_byte, asm_rgb[7:0]};
              end
              phase_next = phase + 2'd1;
              h_done     = 1'b1;
            end
          end
          default: begin
            if (phase == 2'd3) begin
              emit_req  = 1'b1;
              emit_clr  = 1'b1;
              emit_rgb  = asm_rgb;
              emit_last = 1'b1;
            end else begin
              case (phase)
                2'd0:    asm_next = {16'd0, h_byte};
                2'd1:    asm_next = {asm_rgb[23:16], h_byte, asm_rgb[7:0]};
                default: asm_next = {h_byte, asm_rgb[15:0]};
              endcase
              phase_next = phase + 2'd1;
              h_done     = 1'b1;
            end
          end
        endcase

        if (emit_req && credit) begin
          issue    = 1'b1;
          h_done   = emit_last;
          sub_next = emit_last ? 3'd0 : sub + 3'd1;
          if (end_now) begin
            col_next = '0;
            pad_next = pad_arm;
          end else begin
            col_next = col + COL_W'(1);
          end
          if (emit_clr) begin
            phase_next = 2'd0;
            asm_next   = 24'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      pad     <= 2'd0;
      phase   <= 2'd0;
      asm_rgb <= 24'd0;
      sub     <= 3'd0;
    end else begin
      col     <= col_next;
      pad     <= pad_next;
      phase   <= phase_next;
      asm_rgb <= asm_next;
      sub     <= sub_next;
    end
  end

  // -------------------------------------------------------------------------
  // Palette memory: one write port, one registered read port. Writes and
  // reads come from the same ordered request stream, one per cycle, so a
  // read always sees every earlier load.
  // -------------------------------------------------------------------------
  assign mem_re  = issue && emit_pal;
  assign rd_addr = emit_idx[PAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pal_mem[h_pidx[PAL_AW-1:0]] <= h_pcolor;
    end
    if (mem_re) begin
      mem_q <= pal_mem[rd_addr];
    end
  end

  // Lookup stage: hold pixel attributes while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_pal  <= emit_pal;
      p_rgb  <= emit_rgb;
      p_last <= emit_last;
      p_end  <= end_now;
    end
  end

  // -------------------------------------------------------------------------
  // Output queue: parts the decoder from a stalling receiver.
  // -------------------------------------------------------------------------
  assign q_push = p_valid;
  assign q_pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr] <= '{rgb: (p_pal ? mem_q : p_rgb), last: p_last, row_end: p_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        q_wr <= q_wr + FIFO_AW'(1);
      end
      if (q_pop) begin
        q_rd <= q_rd + FIFO_AW'(1);
      end
      q_count <= q_count + FIFO_CW'(q_push) - FIFO_CW'(q_pop);
    end
  end

  assign q_head      = q_mem[q_rd];
  assign out_valid   = (q_count != '0);
  assign red         = q_head.rgb[23:16];
  assign green       = q_head.rgb[15:8];
  assign blue        = q_head.rgb[7:0];
  assign last_of_run = q_head.last;
  assign row_end     = q_head.row_end;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `BPU_ASSERT_IMP(a_push_has_room, p_valid, q_count < FIFO_CW'(FIFO_DEPTH),
                  "output queue overflow")
  `BPU_ASSERT_ALW(a_port_exclusive, !(mem_we && mem_re),
                  "palette write and read in one cycle")
  `BPU_ASSERT_IMP(a_1bpp_bounded, issue && pixel_format == FMT_1BPP && sub == 3'd7,
                  emit_last, "1bpp byte ran past eight pixels")
  `BPU_ASSERT_NXT(a_issue_reaches_stage, issue, p_valid,
                  "issued pixel lost before lookup stage")

endmodule

### dv/bpu_pixel_checker.sv
// ---------------------------------------------------------------------------
// BMP pixel unpacker checker
// Watches the configuration, request and pixel channels, decodes every
// accepted request into the pixels it should produce and compares them in
// order against the pixels the unpacker hands out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpu_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        last_of_run,
  input  logic        row_end,
  output int          mismatches,
  output int          pixels_owed
);
  import bpu_pkg::*;

  logic [23:0]      palette [PAL_ENTRIES];
  logic [COL_W-1:0] column;
  logic [1:0]       phase;
  logic [23:0]      assembly;
  logic [1:0]       pad_left;
  logic [2:0]       fmt;
  logic [12:0]      width_reg;
  pixel_t           expected_pixels [$];

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned row_bytes(int unsigned w);
    case (fmt)
      FMT_1BPP:  return (w + 7) / 8;
      FMT_4BPP:  return (w + 1) / 2;
      FMT_8BPP:  return w;
      FMT_24BPP: return w * 3;
      default:   return w * 4;
    endcase
  endfunction

  // Queue one pixel, advance the column and arm the row padding at row end.
  task automatic issue_pixel(input logic [23:0] rgb, input logic last);
    int unsigned w;
    pixel_t      p;
    w         = active_width();
    p.rgb     = rgb;
    p.last    = last;
    p.row_end = (column + 1 >= w);
    expected_pixels.push_back(p);
    if (p.row_end) begin
      column   = '0;
      pad_left = 2'(4 - (row_bytes(w) % 4));
    end else begin
      column = column + 1'b1;
    end
  endtask

  task automatic decode_request(input logic k, input logic [7:0] b,
                                input logic [7:0] idx, input logic [23:0] color);
    int unsigned w;
    int unsigned n;
    int          i;
    if (k == KIND_PALETTE) begin
      palette[idx] = color;
      return;
    end
    if (fmt > FMT_32BPP) return;
    if (pad_left != 0) begin
      pad_left = pad_left - 1'b1;
      return;
    end
    case (fmt)
      FMT_1BPP: begin
        w = active_width();
        n = (column < w) ? w - column : 1;
        if (n > 8) n = 8;
        for (i = 0; i < n; i++) begin
          issue_pixel(b[7-i] ? 24'hFFFFFF : 24'h000000, i == n - 1);
        end
      end
      FMT_4BPP: begin
        w = active_width();
        if (column + 1 < w) begin
          issue_pixel(palette[b[7:4]], 1'b0);
          issue_pixel(palette[b[3:0]], 1'b1);
        end else begin
          issue_pixel(palette[b[7:4]], 1'b1);
        end
      end
      FMT_8BPP: issue_pixel(palette[b], 1'b1);
      FMT_24BPP: begin
        if (phase >= 2) begin
          w        = 32'({b, assembly[15:0]});
          phase    = '0;
          assembly = '0;
          issue_pixel(w[23:0], 1'b1);
        end else begin
          if (phase == 0) assembly = {16'h0, b};
          else assembly[15:8] = b;
          phase = phase + 1'b1;
        end
      end
      default: begin
        if (phase == 3) begin
          w        = 32'(assembly);
          phase    = '0;
          assembly = '0;
          issue_pixel(w[23:0], 1'b1);
        end else begin
          case (phase)
            2'd0:    assembly = {16'h0, b};
            2'd1:    assembly[15:8] = b;
            default: assembly[23:16] = b;
          endcase
          phase = phase + 1'b1;
        end
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      column    = '0;
      phase     = '0;
      assembly  = '0;
      pad_left  = '0;
      fmt       = FMT_24BPP;
      width_reg = 13'd1;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PIXEL_FORMAT) fmt = cfg_data[2:0];
        else width_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        decode_request(kind, data_byte, palette_index, palette_color);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel %h%h%h arrived with none expected", red, green, blue);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.rgb[23:16], red);
          check_field("green", want.rgb[15:8], green);
          check_field("blue", want.rgb[7:0], blue);
          check_field("last_of_run", {7'h0, want.last}, {7'h0, last_of_run});
          check_field("row_end", {7'h0, want.row_end}, {7'h0, row_end});
        end
      end
    end
    pixels_owed <= expected_pixels.size();
  end

endmodule

### dv/bmp_pixel_unpacker_top_tb.sv
// ---------------------------------------------------------------------------
// BMP pixel unpacker testbench
// Drives palette loads and pixel-array bytes through every pixel format and
// a range of row widths, with random gaps on both channels, while a checker
// beside the unpacker predicts each pixel and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmp_pixel_unpacker_top_tb;
  import bpu_pkg::*;

  // Format codes the unpacker must ignore.
  localparam logic [2:0] FMT_RESERVED_LO = 3'd5;
  localparam logic [2:0] FMT_RESERVED_HI = 3'd7;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_REQUESTS = 120;
  // Pipeline is three deep; give it some margin before touching registers.
  localparam int SETTLE_CYCLES   = 8;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_valid     = 1'b0;
  logic        cfg_index     = REG_PIXEL_FORMAT;
  logic [12:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        kind          = KIND_PIXEL;
  logic [7:0]  data_byte     = '0;
  logic [7:0]  palette_index = '0;
  logic [23:0] palette_color = '0;
  logic        out_ready     = 1'b0;

  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_run;
  logic        row_end;

  int          mismatches;
  int          pixels_owed;
  int          cycles      = 0;
  int          stall_left  = 0;
  // When set, neither side inserts gaps.
  bit          calm        = 1'b0;
  // Palette entries that hold a defined color.
  bit          pal_loaded [PAL_ENTRIES];

  bmp_pixel_unpacker_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_of_run   (last_of_run),
    .row_end       (row_end)
  );

  bpu_pixel_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_color (palette_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_of_run   (last_of_run),
    .row_end       (row_end),
    .mismatches    (mismatches),
    .pixels_owed   (pixels_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing pixel ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Pixel receiver: stall in random bursts unless things are calm.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request and hold it until accepted. Valid is left high so a
  // following request goes out back to back; a gap or a drain lowers it.
  task automatic send_request(input logic k, input logic [7:0] b,
                              input logic [7:0] idx, input logic [23:0] color);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    data_byte     <= b;
    palette_index <= idx;
    palette_color <= color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Unused payload fields carry noise so every bit toggles.
  task automatic send_pixel(input logic [7:0] b);
    send_request(KIND_PIXEL, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic load_palette(input logic [7:0] idx, input logic [23:0] color);
    send_request(KIND_PALETTE, 8'($urandom), idx, color);
    pal_loaded[idx] = 1'b1;
  endtask

  // Hold off new requests until every predicted pixel has come out, then let
  // requests that produce nothing work through the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram both registers once the unpacker is idle.
  task automatic configure(input logic [2:0] f, input logic [12:0] w);
    drain();
    write_register(REG_PIXEL_FORMAT, 13'(f));
    write_register(REG_IMAGE_WIDTH, w);
    cfg_valid <= 1'b0;
  endtask

  // In 8bpp only index colors that were loaded; anything goes elsewhere.
  function automatic logic [7:0] pick_byte(logic [2:0] f);
    logic [7:0] idx;
    if (f != FMT_8BPP) return 8'($urandom);
    do idx = 8'($urandom_range(0, 255)); while (!pal_loaded[idx]);
    return idx;
  endfunction

  // Bytes per stored row including padding to four bytes.
  function automatic int unsigned row_stride(logic [2:0] f, int unsigned w);
    int unsigned raw;
    case (f)
      FMT_1BPP:  raw = (w + 7) / 8;
      FMT_4BPP:  raw = (w + 1) / 2;
      FMT_8BPP:  raw = w;
      FMT_24BPP: raw = w * 3;
      default:   raw = w * 4;
    endcase
    return (raw + 3) / 4 * 4;
  endfunction

  initial begin
    int          sent;
    int          n_bytes;
    int          i;
    int unsigned eff;
    int unsigned stride;
    logic [2:0]  f;
    logic [12:0] w;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (24bpp, width 1): one pixel from B,G,R, then drop the
    // single padding byte.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    send_pixel(8'h5C);

    // Load the low sixteen entries so every 4bpp nibble is defined, plus the
    // top entry and one with the high index bit set.
    for (i = 0; i < 16; i++) begin
      load_palette(8'(i), (i == 0) ? 24'h000000 : (i == 15) ? 24'hFFFFFF : 24'($urandom));
    end
    load_palette(8'hFF, 24'($urandom));
    load_palette(8'h80, 24'($urandom));

    // 1bpp, width 13: a full white byte, then a byte cut short at row end,
    // then two padding bytes.
    configure(FMT_1BPP, 13'd13);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hA5);
    send_pixel(8'h5A);

    // 4bpp, width 3: high nibble first, odd width leaves one nibble unused.
    configure(FMT_4BPP, 13'd3);
    send_pixel(8'hF0);
    send_pixel(8'h5A);
    send_pixel(8'h33);
    send_pixel(8'hCC);

    // 8bpp at an oversized width, then shrink the width mid-row so the next
    // pixel closes the row.
    configure(FMT_8BPP, 13'h1FFF);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h0F);
    configure(FMT_8BPP, 13'd2);
    send_pixel(8'h05);
    send_pixel(8'h0A);
    send_pixel(8'h0B);

    // Width zero in 32bpp, stop after three bytes, switch to 24bpp: the next
    // byte completes the pixel as red.
    configure(FMT_32BPP, 13'd0);
    send_pixel(8'h11);
    send_pixel(8'h22);
    send_pixel(8'h33);
    configure(FMT_24BPP, 13'd0);
    send_pixel(8'hAB);
    send_pixel(8'h01);

    // Reserved formats swallow bytes without touching the stream.
    configure(FMT_RESERVED_LO, 13'd5);
    send_pixel(8'h7E);
    configure(FMT_RESERVED_HI, 13'd5);
    send_pixel(8'h81);

    // Widest legal row, leave it open for the random part to cut.
    configure(FMT_32BPP, 13'(MAX_WIDTH));
    send_pixel(8'h12);
    send_pixel(8'h34);
    send_pixel(8'h56);
    send_pixel(8'h78);

    // Random part: mostly whole padded rows at small widths, now and then a
    // short burst at a large width or in a reserved format.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      calm <= ($urandom_range(0, 3) == 0) || (sent > RANDOM_REQUESTS * 4 / 5);
      f = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 11) == 0) f = 3'($urandom_range(FMT_RESERVED_LO, FMT_RESERVED_HI));
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       w = 13'd0;
          1:       w = 13'(MAX_WIDTH);
          2:       w = 13'($urandom_range(MAX_WIDTH + 1, 8191));
          default: w = 13'($urandom_range(1, MAX_WIDTH));
        endcase
      end else begin
        w = 13'($urandom_range(1, 9));
      end
      configure(f, w);

      eff    = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      stride = row_stride(f, eff);
      if (f > FMT_32BPP) n_bytes = $urandom_range(1, 4);
      else if (stride > 48 || $urandom_range(0, 5) == 0) n_bytes = $urandom_range(1, 12);
      else n_bytes = stride * $urandom_range(1, 3);

      for (i = 0; i < n_bytes; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          load_palette(8'($urandom), 24'($urandom));
          sent++;
        end
        send_pixel(pick_byte(f));
        if (f <= FMT_32BPP) sent++;
      end
    end

    // Flush everything, then give the verdict.
    calm <= 1'b1;
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pixels_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### bmp_pixel_unpacker_top.f
+incdir+src
src/bpu_pkg.sv
src/bmp_pixel_unpacker_top.sv
dv/bpu_pixel_checker.sv
dv/bmp_pixel_unpacker_top_tb.sv
